/* design/ecnfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnfa_pkg
// shared constants, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ecnfa_pkg;

  localparam int COUNT_BITS_DEF = 40;

  localparam int Q16_W   = 17;
  localparam int SEG_W   = 10;
  localparam int SEQ_W   = 32;
  localparam int SBYTE_W = 16;
  localparam int BYTES_W = SEG_W + SBYTE_W;
  localparam int FRAC_W  = 16;

  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [Q16_W-1:0]   GAIN_RST    = 17'd4096;
  localparam logic [Q16_W-1:0]   INIT_A_RST  = 17'h10000;
  localparam logic [SBYTE_W-1:0] SEG_B_RST   = 16'd536;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_B   = 2'd2;

  typedef struct packed {
    logic load;      // capture the request
    logic bytes;     // acked bytes product
    logic acc;       // counter update and window check
    logic div_init;  // start fraction division
    logic div_step;  // one quotient bit
    logic mix1;      // (1-g)*alpha, final fraction
    logic mix2;      // + g*m
    logic commit;    // new alpha, clear counters, re-latch window end
    logic ssth;      // ssthresh product
    logic out_load;  // load output register
  } ecnfa_cmd_t;

  typedef struct packed {
    logic closed;
  } ecnfa_sts_t;

  function automatic logic [Q16_W-1:0] clamp_q16(input logic [Q16_W-1:0] v);
    clamp_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

/* design/ecnfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnfa_ctrl
// sequencer for one ack event and the output handshake
// ----------------------------------------------------------------------------
module ecnfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ecnfa_pkg::ecnfa_sts_t sts,
  output ecnfa_pkg::ecnfa_cmd_t cmd
);
  import ecnfa_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BYTES  = 4'd1;
  localparam logic [3:0] ST_ACC    = 4'd2;
  localparam logic [3:0] ST_CHK    = 4'd3;
  localparam logic [3:0] ST_DIV    = 4'd4;
  localparam logic [3:0] ST_MIX1   = 4'd5;
  localparam logic [3:0] ST_MIX2   = 4'd6;
  localparam logic [3:0] ST_COMMIT = 4'd7;
  localparam logic [3:0] ST_SSTH   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  localparam logic [3:0] DIV_LAST = 4'(FRAC_W - 1);

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] step;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_BYTES;
        end
      end
      ST_BYTES: begin
        cmd.bytes  = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (sts.closed) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_SSTH;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) state_next = ST_MIX1;
      end
      ST_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.mix2   = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_SSTH;
      end
      ST_SSTH: begin
        cmd.ssth   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_init) step <= '0;
      else if (cmd.div_step) step <= step + 4'd1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* design/ecnfa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnfa_dp
// counters, window tracking, fraction divider, ewma and ssthresh arithmetic
// ----------------------------------------------------------------------------
module ecnfa_dp #(
  parameter int COUNT_BITS = ecnfa_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ecnfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecnfa_pkg::Q16_W-1:0]           cfg_data,
  input  logic [ecnfa_pkg::IN_DATA_W-1:0]       in_data,
  input  logic                                  in_ece,
  output logic [ecnfa_pkg::OUT_DATA_W-1:0]      out_data,
  output logic                                  out_closed,
  input  ecnfa_pkg::ecnfa_cmd_t                 cmd,
  output ecnfa_pkg::ecnfa_sts_t                 sts
);
  import ecnfa_pkg::*;

  localparam int                  PAD_W   = COUNT_BITS - BYTES_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam int                  MIX_W   = 2 * Q16_W;
  localparam int                  SSTH_PW = SEQ_W + Q16_W + 1;

  // configuration
  logic [Q16_W-1:0]   gain;
  logic [SBYTE_W-1:0] seg_bytes;

  // request capture
  logic [SEG_W-1:0] segs;
  logic             ece;
  logic [SEQ_W-1:0] acked;
  logic [SEQ_W-1:0] next_tx;
  logic [SEQ_W-1:0] cwnd;

  // state
  logic [COUNT_BITS-1:0] ecn_cnt;
  logic [COUNT_BITS-1:0] total_cnt;
  logic [SEQ_W-1:0]      win_end;
  logic                  win_valid;
  logic [Q16_W-1:0]      alpha;

  // working registers
  logic [BYTES_W-1:0]    bytes;
  logic                  closed;
  logic [COUNT_BITS:0]   rem;
  logic [FRAC_W-1:0]     quo;
  logic [Q16_W-1:0]      m_frac;
  logic [MIX_W-1:0]      prod_a;
  logic [MIX_W-1:0]      mix;
  logic [SEQ_W-1:0]      ssth;

  logic [COUNT_BITS:0]   tot_sum;
  logic [COUNT_BITS:0]   ecn_sum;
  logic [SEQ_W-1:0]      end_eff;
  logic [SEQ_W-1:0]      seq_diff;
  logic [Q16_W-1:0]      g_eff;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   den_ext;
  logic [Q16_W-1:0]      alpha_new;
  logic [SSTH_PW-1:0]    ssth_prod;

  assign tot_sum  = {1'b0, total_cnt} + {1'b0, {PAD_W{1'b0}}, bytes};
  assign ecn_sum  = {1'b0, ecn_cnt} + {1'b0, {PAD_W{1'b0}}, bytes};
  assign end_eff  = win_valid ? win_end : next_tx;
  assign seq_diff = acked - end_eff;
  assign g_eff    = clamp_q16(gain);
  assign rem_sh   = {rem[COUNT_BITS-1:0], 1'b0};
  assign den_ext  = {1'b0, total_cnt};
  assign alpha_new = clamp_q16(mix[Q16_W+FRAC_W-1:FRAC_W]);
  assign ssth_prod = SSTH_PW'(cwnd) *
                     SSTH_PW'({1'b0, ONE_Q16} + {1'b0, ONE_Q16} - {1'b0, alpha});

  assign sts.closed = closed;

  // configuration and alpha
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RST;
      seg_bytes <= SEG_B_RST;
      alpha     <= clamp_q16(INIT_A_RST);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN:   gain      <= cfg_data;
          REG_INIT_A: alpha     <= clamp_q16(cfg_data);
          REG_SEG_B:  seg_bytes <= cfg_data[SBYTE_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.commit) alpha <= alpha_new;
    end
  end

  // counters and window end
  always_ff @(posedge clk) begin
    if (rst) begin
      ecn_cnt   <= '0;
      total_cnt <= '0;
      win_end   <= '0;
      win_valid <= 1'b0;
      closed    <= 1'b0;
    end else begin
      if (cmd.acc) begin
        total_cnt <= tot_sum[COUNT_BITS] ? CNT_MAX : tot_sum[COUNT_BITS-1:0];
        if (ece) ecn_cnt <= ecn_sum[COUNT_BITS] ? CNT_MAX : ecn_sum[COUNT_BITS-1:0];
        win_end   <= end_eff;
        win_valid <= 1'b1;
        closed    <= !seq_diff[SEQ_W-1];
      end
      if (cmd.commit) begin
        ecn_cnt   <= '0;
        total_cnt <= '0;
        win_end   <= next_tx;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      segs    <= in_data[9:0];
      acked   <= in_data[41:10];
      next_tx <= in_data[73:42];
      cwnd    <= in_data[105:74];
      ece     <= in_ece;
    end
    if (cmd.bytes) bytes <= BYTES_W'(segs) * BYTES_W'(seg_bytes);
    // restoring division, one quotient bit a cycle
    if (cmd.div_init) begin
      rem <= {1'b0, ecn_cnt};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= den_ext) begin
        rem <= rem_sh - den_ext;
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.mix1) begin
      prod_a <= MIX_W'(ONE_Q16 - g_eff) * MIX_W'(alpha);
      if (total_cnt == '0)           m_frac <= '0;
      else if (ecn_cnt >= total_cnt) m_frac <= ONE_Q16;
      else                           m_frac <= {1'b0, quo};
    end
    if (cmd.mix2) mix <= prod_a + MIX_W'(g_eff) * MIX_W'(m_frac);
    if (cmd.ssth) ssth <= ssth_prod[48:17];
    if (cmd.out_load) begin
      out_data   <= {7'b0, ssth, alpha};
      out_closed <= closed;
    end
  end

endmodule

/* design/ecn_fraction_alpha_estimator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecn_fraction_alpha_estimator_top
// dctcp style ecn marked-fraction and alpha estimator
// ----------------------------------------------------------------------------
// Each ack request adds segments_acked * segment_bytes to a saturating total
// byte counter, and to the ecn byte counter when ece_seen is set. The first
// request after reset latches next_tx_seq as the window end; once acked_seq
// reaches it (serial-number compare) the marked fraction ecn/total is formed
// in Q0.16 by a restoring divider, alpha moves towards it with weight gain,
// the counters clear and the window end is re-latched. Every request returns
// alpha and ssthresh = cwnd * (1 - alpha/2). A request that does not close a
// window goes through the bytes, accumulate, check and ssthresh states to the
// result register; one that closes a window also runs the one-bit-a-step
// restoring divider for 16 quotient bits and the two ewma multiplies one after
// the other, then commits. A new request is taken only once the block is back
// in idle. The result sits in an output register, so the next request is
// taken while it waits for m_tready; a later result that finds it still full
// holds the block until it drains. Configuration registers should only be
// written while no request is in progress.
// ----------------------------------------------------------------------------
module ecn_fraction_alpha_estimator_top #(
  parameter int COUNT_BITS = ecnfa_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [ecnfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecnfa_pkg::Q16_W-1:0]       cfg_data,
  // ack requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // segments_acked[9:0], acked_seq[41:10], next_tx_seq[73:42],
  // cwnd_bytes[105:74], zero pad
  input  logic [ecnfa_pkg::IN_DATA_W-1:0]   s_tdata,
  // ece_seen
  input  logic                              s_tuser,
  // results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // alpha_out[16:0], ssthresh_out[48:17], zero pad
  output logic [ecnfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  // window_closed
  output logic                              m_tuser
);
  import ecnfa_pkg::*;

  ecnfa_cmd_t cmd;
  ecnfa_sts_t sts;

  // sequencer
  ecnfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  ecnfa_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .in_ece     (s_tuser),
    .out_data   (m_tdata),
    .out_closed (m_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // one request at a time: no new request straight after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_tvalid || m_tready)
    else $error("result register overwritten");

  // alpha stays within one
  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[Q16_W-1:0] <= ONE_Q16)
    else $error("alpha above one");

endmodule

/* tb/sv/ecnfa_alpha_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecnfa_alpha_checker
// watches the config port and both streams, predicts every result and checks
// ----------------------------------------------------------------------------
// Keeps its own copy of the registers, the byte counters, the window end and
// alpha. Each accepted ack request is run through the predictor and the
// expected result is queued. Each accepted result is compared field by field
// with the oldest queued one. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module ecnfa_alpha_checker #(
  parameter int COUNT_BITS = ecnfa_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ecnfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecnfa_pkg::Q16_W-1:0]       cfg_data,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // segments_acked[9:0], acked_seq[41:10], next_tx_seq[73:42],
  // cwnd_bytes[105:74], zero pad
  input  logic [ecnfa_pkg::IN_DATA_W-1:0]   s_tdata,
  // ece_seen
  input  logic                              s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // alpha_out[16:0], ssthresh_out[48:17], zero pad
  input  logic [ecnfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  // window_closed
  input  logic                              m_tuser,
  output int                                mismatches,
  output int                                outstanding
);
  import ecnfa_pkg::*;

  typedef struct packed {
    logic [Q16_W-1:0] alpha;
    logic [31:0]      ssthresh;
    logic             closed;
  } alpha_result_t;

  logic [Q16_W-1:0]   gain_reg;
  logic [SBYTE_W-1:0] seg_bytes_reg;
  logic [63:0]        ecn_bytes;
  logic [63:0]        total_bytes;
  logic [31:0]        window_end;
  logic               window_armed;
  logic [Q16_W-1:0]   alpha_q16;

  alpha_result_t      pending_results[$];
  alpha_result_t      want;
  alpha_result_t      got;

  // saturating add at the counter width
  function automatic logic [63:0] count_add(input logic [63:0] acc, input logic [63:0] inc);
    logic [63:0] top_val;
    top_val = {64{1'b1}} >> (64 - COUNT_BITS);
    count_add = (inc >= top_val - acc) ? top_val : acc + inc;
  endfunction

  function automatic alpha_result_t predict_ack(
    input logic [SEG_W-1:0] segs,
    input logic             ece,
    input logic [31:0]      acked,
    input logic [31:0]      next_tx,
    input logic [31:0]      cwnd
  );
    logic [63:0]   bytes;
    logic [63:0]   weight;
    logic [63:0]   mark;
    logic [63:0]   blend;
    logic [127:0]  scaled;
    logic [31:0]   lag;
    alpha_result_t r;
    bytes       = 64'(segs) * 64'(seg_bytes_reg);
    total_bytes = count_add(total_bytes, bytes);
    if (ece) ecn_bytes = count_add(ecn_bytes, bytes);
    if (!window_armed) begin
      window_end   = next_tx;
      window_armed = 1'b1;
    end
    // serial compare: at or after the window end
    lag      = acked - window_end;
    r.closed = ~lag[31];
    if (r.closed) begin
      weight = (gain_reg > ONE_Q16) ? 64'(ONE_Q16) : 64'(gain_reg);
      if (total_bytes == 64'd0) mark = 64'd0;
      else if (ecn_bytes >= total_bytes) mark = 64'(ONE_Q16);
      else begin
        scaled = {64'd0, ecn_bytes} << 16;
        mark   = 64'(scaled / 128'(total_bytes));
      end
      blend       = ((64'(ONE_Q16) - weight) * 64'(alpha_q16) + weight * mark) >> 16;
      alpha_q16   = (blend > 64'(ONE_Q16)) ? ONE_Q16 : blend[Q16_W-1:0];
      ecn_bytes   = 64'd0;
      total_bytes = 64'd0;
      window_end  = next_tx;
    end
    r.alpha    = alpha_q16;
    r.ssthresh = 32'((64'(cwnd) * ((64'(ONE_Q16) << 1) - 64'(alpha_q16))) >> 17);
    predict_ack = r;
  endfunction

  task automatic count_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t %s", $realtime, msg);
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      gain_reg       = GAIN_RST;
      seg_bytes_reg  = SEG_B_RST;
      alpha_q16      = (INIT_A_RST > ONE_Q16) ? ONE_Q16 : INIT_A_RST;
      ecn_bytes      = 64'd0;
      total_bytes    = 64'd0;
      window_end     = 32'd0;
      window_armed   = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN: gain_reg = cfg_data;
          REG_INIT_A: begin
            alpha_q16      = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;
          end
          REG_SEG_B: seg_bytes_reg = cfg_data[SBYTE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(predict_ack(s_tdata[9:0], s_tuser, s_tdata[41:10],
                                              s_tdata[73:42], s_tdata[105:74]));
      end
      if (m_tvalid && m_tready) begin
        got.alpha    = m_tdata[16:0];
        got.ssthresh = m_tdata[48:17];
        got.closed   = m_tuser;
        if (pending_results.size() == 0) begin
          count_fault($sformatf("unexpected result: alpha %0d ssthresh %0d closed %0d",
                                got.alpha, got.ssthresh, got.closed));
        end else begin
          want = pending_results.pop_front();
          if (got.alpha !== want.alpha || got.ssthresh !== want.ssthresh ||
              got.closed !== want.closed) begin
            count_fault($sformatf({"result mismatch: alpha exp %0d got %0d, ",
                                   "ssthresh exp %0d got %0d, closed exp %0d got %0d"},
                                  want.alpha, got.alpha, want.ssthresh, got.ssthresh,
                                  want.closed, got.closed));
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

/* tb/sv/tb_ecn_fraction_alpha_estimator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ecn_fraction_alpha_estimator_top
// stimulus and verdict for the ecn fraction alpha estimator
// ----------------------------------------------------------------------------
// A short directed run walks the window compare edges, sequence wrap, empty
// windows and the register clamps. A run of maximum-size marked acks builds
// byte counts close to the 32-bit limit in one long window. The bulk is random
// phases: each one sets the registers while the block is idle, then sends
// mostly well-formed ack streams with random content, mixed with stale acks
// and pure noise. Both sides idle at random. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_ecn_fraction_alpha_estimator_top;
  import ecnfa_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int STALL_MAX      = 18;
  localparam int DRAIN_CYCLES   = 40;     // above the window-close request period
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SAT_ACKS       = 60;     // max-size acks, counts grow close to the 32-bit limit
  localparam int RANDOM_ACKS    = 1800;
  localparam int PHASES         = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [Q16_W-1:0]      cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tready  = 1'b0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;
  wire                   m_tuser;

  int          mismatches;
  int          outstanding;
  int          quiet_cycles = 0;
  int          sink_wait    = 0;
  int          stall_draw;
  bit          src_idle     = 1'b0;
  bit          sink_idle    = 1'b0;

  // sequence space of the simulated connection, plus a mirror of the window
  // end so that directed requests can land exactly on it
  logic [31:0] flow_una;
  logic [31:0] flow_nxt;
  logic [31:0] track_end   = 32'd0;
  bit          track_valid = 1'b0;

  always #5 clk = ~clk;

  ecn_fraction_alpha_estimator_top #(
    .COUNT_BITS (COUNT_BITS_DEF)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  ecnfa_alpha_checker #(
    .COUNT_BITS (COUNT_BITS_DEF)
  ) alpha_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // result sink: after each taken result it may hold m_tready low for a
  // drawn number of cycles; the countdown runs whether or not a result waits,
  // so stalls land on every stage of the block's work
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else if (m_tready) begin
      if (m_tvalid && sink_idle) begin
        stall_draw = $urandom_range(0, STALL_MAX);
        if (stall_draw != 0) begin
          m_tready  <= 1'b0;
          sink_wait <= stall_draw;
        end
      end
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // cycles with no request and no result moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // one ack request; returns just after the edge that took it
  task automatic send_ack(
    input logic [SEG_W-1:0] segs,
    input logic             ece,
    input logic [31:0]      acked,
    input logic [31:0]      nxt,
    input logic [31:0]      cwnd
  );
    int          gap;
    logic [31:0] lag;
    gap = src_idle ? $urandom_range(0, STALL_MAX) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({cwnd, nxt, acked, segs});
    s_tuser  <= ece;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // follow the window end so later requests can hit or miss it on purpose
    if (!track_valid) begin
      track_end   = nxt;
      track_valid = 1'b1;
    end
    lag = acked - track_end;
    if (!lag[31]) track_end = nxt;
  endtask

  // stop sending and let the block fall idle before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q16_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_cwnd();
    case ($urandom_range(0, 9))
      0:       pick_cwnd = 32'd0;
      1:       pick_cwnd = 32'hFFFF_FFFF;
      2, 3:    pick_cwnd = $urandom;
      default: pick_cwnd = $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  initial begin
    int          mark_pct;
    int          kind;
    logic [9:0]  segs;
    logic [31:0] lead;

    flow_una = $urandom;
    flow_nxt = flow_una;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed: window compare and wrap, reset registers
    // first request arms the window end at 1000, nothing closes
    send_ack(10'd0, 1'b0, 32'd0, 32'd1000, 32'd0);
    // one short of the end, full-size marked ack
    send_ack(10'd1023, 1'b1, 32'd999, 32'd2000, 32'hFFFF_FFFF);
    // exactly on the end: closes with a partly marked window
    send_ack(10'd10, 1'b0, 32'd1000, 32'd5000, 32'hFFFF_FFFF);
    // closes with no bytes counted, marked fraction is zero; end moves near wrap
    send_ack(10'd0, 1'b0, 32'd5000, 32'hFFFF_FF00, 32'd1);
    send_ack(10'd3, 1'b1, 32'hFFFF_FEFF, 32'hFFFF_FF80, 32'd12345);
    // acked seq has wrapped past the end
    send_ack(10'd2, 1'b1, 32'h0000_0010, 32'h9000_0000, 32'h8000_0000);
    // half the sequence space away counts as before the end
    send_ack(10'd1, 1'b0, 32'h1000_0000, 32'h2000_0000, 32'h7FFF_FFFF);
    // one less than half the space counts as after
    send_ack(10'd1, 1'b1, 32'h0FFF_FFFF, 32'h2000_0000, 32'h0000_FFFF);
    send_ack(10'd1023, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // zero gain holds alpha; oversized initial alpha loads as one
    settle();
    write_reg(REG_GAIN, 17'd0);
    write_reg(REG_INIT_A, 17'h1FFFF);
    send_ack(10'd5, 1'b1, track_end, track_end + 32'd100, 32'hFFFF_FFFF);

    // unit gain: alpha jumps straight to the marked fraction
    settle();
    write_reg(REG_GAIN, ONE_Q16);
    write_reg(REG_INIT_A, 17'd0);
    send_ack(10'd4, 1'b1, track_end - 32'd1, track_end + 32'd50, 32'd1000);
    send_ack(10'd4, 1'b0, track_end, track_end + 32'd70, 32'd1000);

    // oversized gain is taken as one; zero segment size counts no bytes
    settle();
    write_reg(REG_GAIN, 17'h1FFFF);
    write_reg(REG_SEG_B, 17'd0);
    send_ack(10'd1023, 1'b1, track_end - 32'd1, track_end + 32'd10, 32'hFFFF_FFFF);
    send_ack(10'd1023, 1'b1, track_end, track_end + 32'd10, 32'hFFFF_FFFF);

    // widest segment size, a write to the spare index, smallest gain
    settle();
    write_reg(REG_SEG_B, 17'h1FFFF);
    write_reg(REG_SPARE, 17'h1ABCD);
    write_reg(REG_INIT_A, ONE_Q16);
    write_reg(REG_GAIN, 17'd1);
    send_ack(10'd1023, 1'b1, track_end - 32'd1, track_end + 32'd10, 32'hFFFF_FFFF);
    send_ack(10'd1, 1'b0, track_end, track_end + 32'd10, 32'hFFFF_FFFF);

    settle();
    write_reg(REG_GAIN, 17'd65535);
    write_reg(REG_SEG_B, 17'd1);
    send_ack(10'd3, 1'b1, track_end - 32'd1, track_end + 32'd10, 32'd65536);
    send_ack(10'd1, 1'b0, track_end, track_end + 32'd10, 32'd65536);

    // ---------------- large byte counts: no idling, one very long window
    settle();
    write_reg(REG_GAIN, ONE_Q16);
    write_reg(REG_SEG_B, 17'd65535);
    send_ack(10'd0, 1'b0, track_end, track_end + 32'h4000_0000, 32'd0);
    for (int n = 0; n < SAT_ACKS; n++) begin
      send_ack(10'd1023, 1'b1, track_end - 32'd1, $urandom, $urandom);
    end
    send_ack(10'd0, 1'b0, track_end, track_end + 32'd1000, 32'hFFFF_FFFF);

    // ---------------- random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       write_reg(REG_GAIN, 17'd0);
        1:       write_reg(REG_GAIN, ONE_Q16);
        2:       write_reg(REG_GAIN, 17'h1FFFF);
        3:       write_reg(REG_GAIN, 17'd1);
        default: write_reg(REG_GAIN, Q16_W'($urandom_range(0, 65536)));
      endcase
      case ($urandom_range(0, 6))
        0:       write_reg(REG_SEG_B, 17'd1);
        1:       write_reg(REG_SEG_B, 17'd65535);
        2:       write_reg(REG_SEG_B, 17'd0);
        3:       write_reg(REG_SEG_B, 17'd1448);
        default: write_reg(REG_SEG_B, Q16_W'($urandom_range(1, 65535)));
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_INIT_A, Q16_W'($urandom_range(0, 17'h1FFFF)));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, Q16_W'($urandom));
      case ($urandom_range(0, 4))
        0:       mark_pct = 0;
        1:       mark_pct = 100;
        2:       mark_pct = 10;
        3:       mark_pct = 90;
        default: mark_pct = 50;
      endcase
      src_idle  = 1'($urandom_range(0, 1));
      sink_idle = 1'($urandom_range(0, 1));

      for (int n = 0; n < RANDOM_ACKS / PHASES; n++) begin
        // stretches with and without idling on each side
        if ($urandom_range(0, 39) == 0) src_idle = !src_idle;
        if ($urandom_range(0, 39) == 0) sink_idle = !sink_idle;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // in-order ack stream; pull it back if noise pushed the end far ahead
          if (track_valid) begin
            lead = track_end - flow_una;
            if (!lead[31] && lead > 32'd200000)
              flow_una = track_end - 32'($urandom_range(0, 3000));
          end
          segs = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 8));
          flow_una = flow_una + 32'(segs) * 32'd1448 + 32'($urandom_range(0, 8000));
          lead = flow_nxt - flow_una;
          if (lead[31]) flow_nxt = flow_una;
          if (flow_nxt - flow_una < 32'd60000)
            flow_nxt = flow_nxt + 32'($urandom_range(0, 30000));
          send_ack(segs, $urandom_range(0, 99) < mark_pct, flow_una, flow_nxt, pick_cwnd());
        end else if (kind < 85) begin
          // stale or duplicate ack from behind the stream
          send_ack(10'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                   flow_una - 32'($urandom_range(0, 100000)), flow_nxt, pick_cwnd());
        end else begin
          send_ack(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom, $urandom);
        end
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
